[sv/fhl_pkg.sv]
// ----------------------------------------------------------------------------
// fhl_pkg: shared definitions for the free hole list allocator
// Status and placement codes, controller states, command and status bundles.
// ----------------------------------------------------------------------------
package fhl_pkg;

  localparam int MAX_HOLES_DEF = 64;
  localparam int SIZE_BITS_DEF = 32;

  // result status
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // placement rule; any other code acts as first fit
  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  localparam logic KIND_ALLOC = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHIFT_UP,
    S_INSERT,
    S_SHIFT_DN,
    S_SHRINK,
    S_RESP
  } fhl_state_t;

  typedef struct packed {
    logic       load;
    logic       scan;
    logic       up_init;
    logic       up_step;
    logic       insert;
    logic       dn_init;
    logic       dn_step;
    logic       shrink;
    logic       set_res;
    logic [1:0] res_status;
    logic       dec_count;
    logic       emit;
  } fhl_cmd_t;

  typedef struct packed {
    logic full;
    logic is_alloc;
    logic scan_done;
    logic found;
    logic exact;
    logic up_done;
    logic dn_done;
    logic out_free;
  } fhl_stat_t;

endpackage

[sv/free_hole_list_allocator.sv]
// ----------------------------------------------------------------------------
// free_hole_list_allocator: free hole list with first, best and worst fit
// Channels: in_* (kind, req_size, req_offset) and out_* (status, hole_index,
// hole_start), both valid/ready; one result transfer per input transfer.
// cfg_wr_en/cfg_wr_data write the fit strategy; write only while idle.
// One request at a time: in_ready is high only while the sequencer is idle.
// A request scans the hole list one entry per cycle through the memory's
// registered read port (a first-fit release skips the scan), then shifts
// entries one per cycle to open or close a gap, through the single read
// and write port.
// The result is held in an output register, so the next request is taken
// while a result still waits; a stalled receiver holds the sequencer only
// when the following result is ready.
// Reset (rst_n low, synchronous) empties the list and selects first fit;
// no clearing pass runs, since only entries below the count are ever read.
// ----------------------------------------------------------------------------
module free_hole_list_allocator
  import fhl_pkg::*;
#(
  parameter int MAX_HOLES = MAX_HOLES_DEF,
  parameter int SIZE_BITS = SIZE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [31:0] in_req_size,
  input  logic [31:0] in_req_offset,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [5:0]  out_hole_index,
  output logic [31:0] out_hole_start
);

  fhl_cmd_t  cmd;
  fhl_stat_t st;

  fhl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  fhl_dpath #(
    .MAX_HOLES (MAX_HOLES),
    .SIZE_BITS (SIZE_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_kind        (in_kind),
    .in_req_size    (in_req_size),
    .in_req_offset  (in_req_offset),
    .cmd            (cmd),
    .st             (st),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_hole_index (out_hole_index),
    .out_hole_start (out_hole_start)
  );

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input transfer taken while a request is in flight");

  a_fail_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> (out_hole_index == 6'd0) &&
    (out_hole_start == 32'd0))
    else $error("failed result carries nonzero index or start");

  a_emit_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> st.out_free)
    else $error("output register overwritten before transfer");

  a_no_insert_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.insert |-> !st.full)
    else $error("insert into a full hole list");
`endif

endmodule

[sv/fhl_ctrl.sv]
// ----------------------------------------------------------------------------
// fhl_ctrl: allocator sequencer
// Steps each request through scan, shift and update phases of the datapath.
// ----------------------------------------------------------------------------
module fhl_ctrl
  import fhl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  fhl_stat_t st,
  output fhl_cmd_t  cmd
);

  fhl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        priority if (st.full && !st.is_alloc) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = ST_FULL;
          state_nxt      = S_RESP;
        end else begin
          cmd.scan = 1'b1;
          if (st.scan_done) begin
            state_nxt = S_DECIDE;
          end
        end
      end
      S_DECIDE: begin
        priority if (!st.is_alloc) begin
          cmd.up_init = 1'b1;
          state_nxt   = S_SHIFT_UP;
        end else if (!st.found) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = ST_NOFIT;
          state_nxt      = S_RESP;
        end else if (st.exact) begin
          cmd.dn_init = 1'b1;
          state_nxt   = S_SHIFT_DN;
        end else begin
          state_nxt = S_SHRINK;
        end
      end
      S_SHIFT_UP: begin
        cmd.up_step = 1'b1;
        if (st.up_done) begin
          state_nxt = S_INSERT;
        end
      end
      S_INSERT: begin
        cmd.insert     = 1'b1;
        cmd.set_res    = 1'b1;
        cmd.res_status = ST_OK;
        state_nxt      = S_RESP;
      end
      S_SHIFT_DN: begin
        cmd.dn_step = 1'b1;
        if (st.dn_done) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = ST_OK;
          cmd.dec_count  = 1'b1;
          state_nxt      = S_RESP;
        end
      end
      S_SHRINK: begin
        cmd.shrink     = 1'b1;
        cmd.set_res    = 1'b1;
        cmd.res_status = ST_OK;
        state_nxt      = S_RESP;
      end
      S_RESP: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

[sv/fhl_dpath.sv]
// ----------------------------------------------------------------------------
// fhl_dpath: hole list storage and search datapath
// Hole memory with registered read, scan compare, shift pipeline, result and
// output registers.
// ----------------------------------------------------------------------------
module fhl_dpath
  import fhl_pkg::*;
#(
  parameter int MAX_HOLES = MAX_HOLES_DEF,
  parameter int SIZE_BITS = SIZE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,
  input  logic        in_kind,
  input  logic [31:0] in_req_size,
  input  logic [31:0] in_req_offset,
  input  fhl_cmd_t    cmd,
  output fhl_stat_t   st,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [5:0]  out_hole_index,
  output logic [31:0] out_hole_start
);

  localparam int AW = $clog2(MAX_HOLES);
  localparam int CW = $clog2(MAX_HOLES + 1);
  localparam int SW = SIZE_BITS;
  localparam int EW = 2 * SIZE_BITS;

  logic [EW-1:0] mem [MAX_HOLES];
  logic [EW-1:0] rdata_r;

  logic [1:0]    strat_r;
  logic          kind_r;
  logic [SW-1:0] size_r, offset_r;
  logic [CW-1:0] count_r, idx_r, pos_r;
  logic          pend_r, found_r;
  logic [AW-1:0] pidx_r;
  logic [SW-1:0] best_size_r, best_off_r;
  logic [1:0]    res_status_r;
  logic [5:0]    res_index_r;
  logic [31:0]   res_start_r;
  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic [5:0]    out_index_r;
  logic [31:0]   out_start_r;

  logic [SW+31:0] in_size_ext, in_off_ext;
  logic [SW+31:0] best_off_ext;
  logic [CW+5:0]  pos_ext;
  logic [SW-1:0]  e_size, e_off;
  logic           is_best, is_worst, is_first, is_alloc;
  logic           below_count, up_issue, fits, rel_hit, rel_take, alloc_upd;
  logic [CW-1:0]  idx_dec;
  logic [AW-1:0]  raddr, waddr;
  logic           we;
  logic [EW-1:0]  wdata;

  assign in_size_ext  = {{SW{1'b0}}, in_req_size};
  assign in_off_ext   = {{SW{1'b0}}, in_req_offset};
  assign best_off_ext = {32'd0, best_off_r};
  assign pos_ext      = {6'd0, pos_r};

  assign e_size   = rdata_r[EW-1:SW];
  assign e_off    = rdata_r[SW-1:0];
  assign is_best  = (strat_r == FIT_BEST);
  assign is_worst = (strat_r == FIT_WORST);
  assign is_first = !is_best && !is_worst;
  assign is_alloc = (kind_r == KIND_ALLOC);

  assign below_count = (idx_r < count_r);
  assign up_issue    = (idx_r > pos_r);
  assign idx_dec     = idx_r - CW'(1);

  assign fits      = (e_size >= size_r);
  assign rel_hit   = is_best ? (e_size >= size_r) : (e_size <= size_r);
  assign rel_take  = pend_r && !is_alloc && !is_first && rel_hit;
  assign alloc_upd = pend_r && is_alloc && fits &&
                     (!found_r || (is_best && (e_size < best_size_r)) ||
                      (is_worst && (e_size > best_size_r)));

  assign st.full      = (count_r == CW'(MAX_HOLES));
  assign st.is_alloc  = is_alloc;
  assign st.scan_done = (!is_alloc && is_first) || rel_take ||
                        (pend_r && is_alloc && is_first && fits) ||
                        (!pend_r && !below_count);
  assign st.found     = found_r;
  assign st.exact     = (best_size_r == size_r);
  assign st.up_done   = !pend_r && !up_issue;
  assign st.dn_done   = !pend_r && !below_count;
  assign st.out_free  = !out_valid_r || out_ready;

  assign raddr = cmd.up_step ? idx_dec[AW-1:0] : idx_r[AW-1:0];

  always_comb begin
    we    = 1'b0;
    waddr = pidx_r;
    wdata = rdata_r;
    priority if (cmd.insert) begin
      we    = 1'b1;
      waddr = pos_r[AW-1:0];
      wdata = {size_r, offset_r};
    end else if (cmd.shrink) begin
      we    = 1'b1;
      waddr = pos_r[AW-1:0];
      wdata = {best_size_r - size_r, best_off_r + size_r};
    end else if ((cmd.up_step || cmd.dn_step) && pend_r) begin
      we = 1'b1;
    end else begin
      we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strat_r     <= FIT_FIRST;
      count_r     <= '0;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        strat_r <= cfg_wr_data;
      end
      out_valid_r <= cmd.emit || (out_valid_r && !out_ready);
      if (cmd.insert) begin
        count_r <= count_r + CW'(1);
      end else if (cmd.dec_count) begin
        count_r <= count_r - CW'(1);
      end
      priority if (cmd.load) begin
        idx_r   <= '0;
        pend_r  <= 1'b0;
        found_r <= 1'b0;
      end else if (cmd.scan) begin
        pend_r <= below_count;
        if (below_count) begin
          idx_r <= idx_r + CW'(1);
        end
        if (alloc_upd) begin
          found_r <= 1'b1;
        end
      end else if (cmd.up_init) begin
        idx_r  <= count_r;
        pend_r <= 1'b0;
      end else if (cmd.up_step) begin
        pend_r <= up_issue;
        if (up_issue) begin
          idx_r <= idx_dec;
        end
      end else if (cmd.dn_init) begin
        idx_r  <= pos_r + CW'(1);
        pend_r <= 1'b0;
      end else if (cmd.dn_step) begin
        pend_r <= below_count;
        if (below_count) begin
          idx_r <= idx_r + CW'(1);
        end
      end else begin
        pend_r <= pend_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r   <= in_kind;
      size_r   <= in_size_ext[SW-1:0];
      offset_r <= in_off_ext[SW-1:0];
      pos_r    <= count_r;
    end else if (cmd.scan) begin
      if (rel_take || alloc_upd) begin
        pos_r <= CW'(pidx_r);
      end
      if (alloc_upd) begin
        best_size_r <= e_size;
        best_off_r  <= e_off;
      end
    end
    if (cmd.scan || cmd.up_step) begin
      pidx_r <= idx_r[AW-1:0];
    end else if (cmd.dn_step) begin
      pidx_r <= idx_dec[AW-1:0];
    end
    if (cmd.set_res) begin
      res_status_r <= cmd.res_status;
      if (cmd.res_status == ST_OK) begin
        res_index_r <= pos_ext[5:0];
        res_start_r <= is_alloc ? best_off_ext[31:0] : 32'd0;
      end else begin
        res_index_r <= 6'd0;
        res_start_r <= 32'd0;
      end
    end
    if (cmd.emit) begin
      out_status_r <= res_status_r;
      out_index_r  <= res_index_r;
      out_start_r  <= res_start_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_hole_index = out_index_r;
  assign out_hole_start = out_start_r;

endmodule

[tb/sv/free_hole_list_allocator_tb.sv]
// ----------------------------------------------------------------------------
// free_hole_list_allocator_tb: self-checking bench for the hole list allocator
// Sends release and allocate requests under every placement rule code, keeps
// its own copy of the hole list to predict each result, and compares results
// field by field. Both channels idle at random; one long output stall fills
// the block up.
// ----------------------------------------------------------------------------
class hole_list_scoreboard;
  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  slot;
    logic [31:0] start;
  } hole_reply_t;

  logic [31:0] hole_len  [fhl_pkg::MAX_HOLES_DEF];
  logic [31:0] hole_base [fhl_pkg::MAX_HOLES_DEF];
  int unsigned live;
  logic [1:0]  rule;
  hole_reply_t reply_q [$];
  int unsigned errors;
  int unsigned n_release, n_alloc, n_full, n_nofit, n_exact, n_shrink;

  function new();
    live = 0;
    rule = fhl_pkg::FIT_FIRST;
    errors = 0;
    n_release = 0;
    n_alloc = 0;
    n_full = 0;
    n_nofit = 0;
    n_exact = 0;
    n_shrink = 0;
  endfunction

  function int unsigned pending();
    return reply_q.size();
  endfunction

  // accepted input transfer: update the list copy and queue the reply
  function void note_input(logic kind, logic [31:0] size, logic [31:0] base);
    int unsigned pos;
    int unsigned i;
    bit found;
    bit stop;
    hole_reply_t r;
    r = '0;
    r.status = fhl_pkg::ST_OK;
    if (kind != fhl_pkg::KIND_ALLOC) begin
      n_release++;
      if (live >= fhl_pkg::MAX_HOLES_DEF) begin
        r.status = fhl_pkg::ST_FULL;
        n_full++;
      end else begin
        pos = live;
        if (rule == fhl_pkg::FIT_BEST) begin
          pos = 0;
          while (pos < live && hole_len[pos] < size) pos++;
        end else if (rule == fhl_pkg::FIT_WORST) begin
          pos = 0;
          while (pos < live && hole_len[pos] > size) pos++;
        end
        for (i = live; i > pos; i--) begin
          hole_len[i]  = hole_len[i-1];
          hole_base[i] = hole_base[i-1];
        end
        hole_len[pos]  = size;
        hole_base[pos] = base;
        live++;
        r.slot = 6'(pos);
      end
    end else begin
      n_alloc++;
      found = 1'b0;
      stop = 1'b0;
      pos = 0;
      for (i = 0; i < live && !stop; i++) begin
        if (hole_len[i] >= size) begin
          if (!found) begin
            found = 1'b1;
            pos = i;
            stop = (rule != fhl_pkg::FIT_BEST) && (rule != fhl_pkg::FIT_WORST);
          end else if (rule == fhl_pkg::FIT_BEST && hole_len[i] < hole_len[pos]) begin
            pos = i;
          end else if (rule == fhl_pkg::FIT_WORST && hole_len[i] > hole_len[pos]) begin
            pos = i;
          end
        end
      end
      if (!found) begin
        r.status = fhl_pkg::ST_NOFIT;
        n_nofit++;
      end else begin
        r.slot = 6'(pos);
        r.start = hole_base[pos];
        if (hole_len[pos] == size) begin
          for (i = pos; i + 1 < live; i++) begin
            hole_len[i]  = hole_len[i+1];
            hole_base[i] = hole_base[i+1];
          end
          live--;
          n_exact++;
        end else begin
          hole_len[pos]  = hole_len[pos] - size;
          hole_base[pos] = hole_base[pos] + size;
          n_shrink++;
        end
      end
    end
    reply_q.push_back(r);
  endfunction

  function void check_result(logic [1:0] status, logic [5:0] slot, logic [31:0] start);
    hole_reply_t exp_r;
    if (reply_q.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected result: status %0d index %0d start %h", status, slot, start);
      return;
    end
    exp_r = reply_q.pop_front();
    if (exp_r.status !== status || exp_r.slot !== slot || exp_r.start !== start) begin
      errors++;
      if (errors <= 10)
        $display("mismatch (exp/got): status %0d/%0d index %0d/%0d start %h/%h",
                 exp_r.status, status, exp_r.slot, slot, exp_r.start, start);
    end
  endfunction
endclass

module free_hole_list_allocator_tb;
  import fhl_pkg::*;

  localparam logic       KIND_RELEASE   = 1'b0;
  localparam logic [1:0] FIT_SPARE      = 2'd3;
  localparam int         WATCHDOG_LIMIT = 3000;
  localparam int         LONG_HOLD      = 300;
  localparam int         TAIL_CYCLES    = 2 * MAX_HOLES_DEF + 20;
  localparam int         PHASE_ITEMS    = 85;
  localparam int         NUM_PHASES     = 8;

  typedef enum {MIX_OPS, FILL_OPS, DRAIN_OPS} op_mix_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [1:0]  cfg_wr_data;
  logic        in_valid;
  logic        in_ready;
  logic        in_kind;
  logic [31:0] in_req_size;
  logic [31:0] in_req_offset;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [5:0]  out_hole_index;
  logic [31:0] out_hole_start;

  hole_list_scoreboard sb;
  bit          calm;
  bit          long_hold_req;
  int unsigned quiet_cycles;

  op_mix_t    mix_plan  [NUM_PHASES] = '{MIX_OPS, FILL_OPS, FILL_OPS, DRAIN_OPS,
                                         MIX_OPS, FILL_OPS, DRAIN_OPS, MIX_OPS};
  logic [1:0] rule_plan [NUM_PHASES] = '{FIT_BEST, FIT_WORST, FIT_FIRST, FIT_SPARE,
                                         FIT_WORST, FIT_BEST, FIT_FIRST, FIT_SPARE};

  free_hole_list_allocator u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_req_size   (in_req_size),
    .in_req_offset (in_req_offset),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_hole_index(out_hole_index),
    .out_hole_start(out_hole_start)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // result side: random stall bursts plus one long hold-off on request
  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready)
        sb.check_result(out_status, out_hole_index, out_hole_start);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left = LONG_HOLD - 1;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 9);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("no transfer for %0d cycles, giving up", WATCHDOG_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic send_item(input logic kind, input logic [31:0] size, input logic [31:0] base);
    int unsigned gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_req_size   <= size;
    in_req_offset <= base;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(kind, size, base);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_rule(input logic [1:0] code);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= code;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.rule = code;
  endtask

  function automatic logic [31:0] extreme_value();
    case ($urandom_range(0, 2))
      0:       return 32'd0;
      1:       return 32'd1;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  task automatic random_item(input op_mix_t mix);
    int unsigned roll;
    int unsigned pick;
    logic        kind;
    logic [31:0] size;
    logic [31:0] base;
    roll = $urandom_range(0, 99);
    case (mix)
      FILL_OPS:  kind = (roll < 75) ? KIND_RELEASE : KIND_ALLOC;
      DRAIN_OPS: kind = (roll < 25) ? KIND_RELEASE : KIND_ALLOC;
      default:   kind = (roll < 50) ? KIND_RELEASE : KIND_ALLOC;
    endcase
    roll = $urandom_range(0, 99);
    if (kind == KIND_RELEASE) begin
      if (roll < 60)      size = $urandom_range(0, 15);
      else if (roll < 75) size = $urandom_range(16, 4096);
      else if (roll < 90) size = $urandom;
      else                size = extreme_value();
      roll = $urandom_range(0, 99);
      if (roll < 70)      base = $urandom;
      else if (roll < 85) base = 32'hFFFF_FFFF - $urandom_range(0, 15);
      else                base = $urandom_range(0, 15);
    end else begin
      pick = (sb.live > 0) ? $urandom_range(0, sb.live - 1) : 0;
      // exact fits and shrinks of holes that are really there
      if (sb.live > 0 && roll < 40)
        size = sb.hole_len[pick];
      else if (sb.live > 0 && roll < 60 && sb.hole_len[pick] != 0)
        size = $urandom % sb.hole_len[pick];
      else if (roll < 85)
        size = $urandom_range(0, 15);
      else if (roll < 95)
        size = $urandom;
      else
        size = extreme_value();
      base = $urandom;
    end
    send_item(kind, size, base);
  endtask

  initial begin : stimulus
    int unsigned p;
    int unsigned k;
    sb = new();
    calm          = 1'b0;
    long_hold_req = 1'b0;
    rst_n         = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = FIT_FIRST;
    in_valid      = 1'b0;
    in_kind       = KIND_RELEASE;
    in_req_size   = '0;
    in_req_offset = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // first fit: empty list, zero size, extremes, offset wrap
    send_item(KIND_ALLOC,   32'd5,         32'd0);
    send_item(KIND_RELEASE, 32'd0,         32'd0);
    send_item(KIND_RELEASE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(KIND_RELEASE, 32'd16,        32'hFFFF_FFF8);
    send_item(KIND_ALLOC,   32'd0,         32'hFFFF_FFFF);
    send_item(KIND_ALLOC,   32'h20,        32'd0);
    send_item(KIND_ALLOC,   32'd16,        32'd0);
    send_item(KIND_ALLOC,   32'hFFFF_FFFF, 32'd0);
    // best fit: ordered insert with ties, smallest fit
    set_rule(FIT_BEST);
    send_item(KIND_RELEASE, 32'd8, 32'd100);
    send_item(KIND_RELEASE, 32'd3, 32'd200);
    send_item(KIND_RELEASE, 32'd8, 32'd300);
    send_item(KIND_RELEASE, 32'd1, 32'd400);
    send_item(KIND_ALLOC,   32'd8, 32'd0);
    send_item(KIND_ALLOC,   32'd2, 32'd0);
    // worst fit: descending insert, largest fit
    set_rule(FIT_WORST);
    send_item(KIND_RELEASE, 32'd5,   32'd500);
    send_item(KIND_RELEASE, 32'd100, 32'd600);
    send_item(KIND_RELEASE, 32'd100, 32'd700);
    send_item(KIND_ALLOC,   32'd4,   32'd0);
    // spare code acts as first fit
    set_rule(FIT_SPARE);
    send_item(KIND_RELEASE, 32'd7, 32'd800);
    send_item(KIND_ALLOC,   32'd7, 32'd0);

    for (p = 0; p < NUM_PHASES; p++) begin
      set_rule(rule_plan[p]);
      calm = (p == NUM_PHASES - 1);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 1 && k == 20)
          long_hold_req = 1'b1;
        random_item(mix_plan[p]);
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    sb.errors += sb.pending();

    $display("Ran %0d releases and %0d allocations over all four rule codes, incl. a long output stall.",
             sb.n_release, sb.n_alloc);
    $display("Hit %0d full-list, %0d no-fit, %0d exact-fit and %0d shrink cases; %0d errors.",
             sb.n_full, sb.n_nofit, sb.n_exact, sb.n_shrink, sb.errors);
    if (sb.errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
